// ----- sv/sdfg_pkg.sv -----
// Shared types and constants for the grouped signed decimal formatter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sdfg_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DIGIT_SLOTS_DEF = 20;
    localparam int VALUE_BITS_DEF  = 64;

    // Fixed field widths.
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int STAT_W  = 2;
    localparam int DIGIT_W = 4;

    // Characters and grouping.
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam int                GROUP_LEN = 3;

    // Status codes carried by result beats.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SIZE = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVF  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_SEP  = 1'b0;
    localparam logic REG_SIZE = 1'b1;

    // Reset values of the registers.
    localparam logic [7:0] SEP_RST  = 8'd0;
    localparam logic [7:0] SIZE_RST = 8'd32;

    typedef logic [DIGIT_W-1:0] t_digit;

    // Per-cycle command broadcast to every digit cell.
    typedef struct packed {
        logic clear;   // load zero
        logic dabble;  // add-3 correction, then shift one bit in from below
        logic advance; // take the digit of the cell below
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGIT,
        S_SEP
    } t_state;

endpackage

`default_nettype wire

// ----- sv/sdfg_digit_cell.sv -----
// One BCD digit cell of the conversion chain.
// Depends on sdfg_pkg for the digit type and the cell command struct.
`default_nettype none

module sdfg_digit_cell
    import sdfg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_bit,      // bit carried from the cell below
    input  wire t_digit    i_digit_lo, // digit of the cell below
    output logic           o_bit,      // bit carried to the cell above
    output t_digit         o_digit
);

    t_digit r_digit;
    t_digit w_adj;

    // Add 3 to digits of five or more so that the following doubling
    // carries into the next decade.
    assign w_adj   = (r_digit >= t_digit'(5)) ? r_digit + t_digit'(3) : r_digit;
    assign o_bit   = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= '0;
        end else if (i_ctl.dabble) begin
            r_digit <= {w_adj[DIGIT_W-2:0], i_bit};
        end else if (i_ctl.advance) begin
            r_digit <= i_digit_lo;
        end
    end

endmodule

`default_nettype wire

// ----- sv/signed_decimal_format_grouped_core.sv -----
// Top level of the grouped signed decimal formatter: control, registers
// and the chain of sdfg_digit_cell instances. Depends on sdfg_pkg.
//
//  Channel   | Direction | Handshake                  | Payload
//  ----------+-----------+----------------------------+-------------------------------
//  input     | in        | i_in_valid / o_in_stall    | i_value
//  result    | out       | o_out_valid / i_out_stall  | o_out_char, o_status, o_last
//  config    | in        | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// One value is accepted, then converted through the digit chain one magnitude bit
// per cycle. The skip state then drops the leading zeros and picks the sign or the
// first digit. Result beats follow (at most 26 for a 64-bit value) while the
// result side does not stall. A zero buffer size skips conversion and gives one
// error beat. Reset (synchronous, active low) returns the controller to idle,
// drops the result valid and loads the register reset values; the digit cells
// need no reset. A stall on the result side holds the output register and pauses
// emission; the chain keeps its digits meanwhile.
`default_nettype none

module signed_decimal_format_grouped_core
    import sdfg_pkg::*;
#(
    parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [VALUE_W-1:0]  i_value,

    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [CHAR_W-1:0]        o_out_char,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_last,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int CNT_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int IDX_W   = $clog2(DIGIT_SLOTS);
    localparam int GRP_TOP = (DIGIT_SLOTS - 1) % GROUP_LEN;

    // Config registers. Writes must come only while the block is idle; not enforced.
    logic [7:0] r_sep;
    logic [7:0] r_size;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep  <= SEP_RST;
            r_size <= SIZE_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_SEP:  r_sep  <= pwdata[7:0];
                REG_SIZE: r_size <= pwdata[7:0];
                default:  r_sep  <= r_sep;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SEP:  prdata = {24'd0, r_sep};
            REG_SIZE: prdata = {24'd0, r_size};
            default:  prdata = '0;
        endcase
    end

    // Controller state and working registers.
    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_mag;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_cnt;
    logic [IDX_W-1:0]        r_idx;  // digits still below the top cell
    logic [1:0]              r_grp;  // r_idx modulo the group length
    logic [7:0]              r_pos;  // characters emitted for this value

    // Output register.
    logic                    r_ovalid;
    logic [CHAR_W-1:0]       r_ochar;
    logic [STAT_W-1:0]       r_ostat;
    logic                    r_olast;

    // Digit chain.
    t_cell_ctl               w_ctl;
    logic   [DIGIT_SLOTS:0]  w_bit;
    t_digit [DIGIT_SLOTS:0]  w_dig;
    t_digit                  w_top;

    logic                    w_accept;
    logic                    w_out_free;
    logic [VALUE_BITS-1:0]   w_x;
    logic [8:0]              w_pos1;
    logic [8:0]              w_pos2;
    logic                    w_sign_ovf;
    logic                    w_dig_ovf;
    logic                    w_skip;
    logic                    w_sep_next;

    // Output-side decisions.
    logic                    w_emit;
    logic [CHAR_W-1:0]       w_char;
    logic [STAT_W-1:0]       w_stat;
    logic                    w_last;
    logic                    w_pos_inc;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || !i_out_stall;

    assign w_x        = i_value[VALUE_BITS-1:0];
    assign w_top      = w_dig[DIGIT_SLOTS];
    assign w_pos1     = {1'b0, r_pos} + 9'd1;
    assign w_pos2     = {1'b0, r_pos} + 9'd2;
    assign w_sign_ovf = (w_pos1 >= {1'b0, r_size});
    assign w_dig_ovf  = (w_pos2 >= {1'b0, r_size});
    assign w_skip     = (w_top == t_digit'(0)) && (r_idx != '0);
    assign w_sep_next = (r_sep != 8'd0) && (r_idx != '0) && (r_grp == 2'd0);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (r_size == 8'd0) ? S_ERR : S_CONV;
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CONV: begin
                if (r_cnt == '0) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (!w_skip) begin
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_state = w_sign_ovf ? S_IDLE : S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_out_free) begin
                    if (w_dig_ovf || (r_idx == '0)) begin
                        n_state = S_IDLE;
                    end else if (w_sep_next) begin
                        n_state = S_SEP;
                    end
                end
            end
            S_SEP: begin
                if (w_out_free) begin
                    n_state = S_DIGIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output logic: the beat to load and the command for the digit chain.
    always_comb begin
        w_emit    = 1'b0;
        w_char    = '0;
        w_stat    = ST_OK;
        w_last    = 1'b0;
        w_pos_inc = 1'b0;
        w_ctl     = '0;
        case (r_state)
            S_IDLE: begin
                w_ctl.clear = w_accept;
            end
            S_ERR: begin
                w_emit = w_out_free;
                w_stat = ST_SIZE;
                w_last = 1'b1;
            end
            S_CONV: begin
                w_ctl.dabble = 1'b1;
            end
            S_SKIP: begin
                w_ctl.advance = w_skip;
            end
            S_SIGN: begin
                w_emit = w_out_free;
                if (w_sign_ovf) begin
                    w_stat = ST_OVF;
                    w_last = 1'b1;
                end else begin
                    w_char    = CH_MINUS;
                    w_pos_inc = w_out_free;
                end
            end
            S_DIGIT: begin
                w_emit = w_out_free;
                if (w_dig_ovf) begin
                    w_stat = ST_OVF;
                    w_last = 1'b1;
                end else begin
                    w_char        = CH_ZERO + {4'd0, w_top};
                    w_last        = (r_idx == '0);
                    w_pos_inc     = w_out_free;
                    w_ctl.advance = w_out_free && (r_idx != '0);
                end
            end
            S_SEP: begin
                w_emit    = w_out_free;
                w_char    = r_sep;
                w_pos_inc = w_out_free;
            end
            default: w_emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ochar <= w_char;
            r_ostat <= w_stat;
            r_olast <= w_last;
        end
    end

    // Working registers. The magnitude of the most negative value is
    // 2^(VALUE_BITS-1), which still fits the unsigned magnitude register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg <= 1'b0;
            r_pos <= '0;
            r_cnt <= '0;
            r_idx <= '0;
            r_grp <= '0;
        end else begin
            if (w_accept) begin
                r_neg <= w_x[VALUE_BITS-1];
                r_mag <= w_x[VALUE_BITS-1] ? (~w_x + 1'b1) : w_x;
                r_cnt <= CNT_W'(VALUE_BITS - 1);
                r_pos <= '0;
            end else if (r_state == S_CONV) begin
                r_mag <= {r_mag[VALUE_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                r_idx <= IDX_W'(DIGIT_SLOTS - 1);
                r_grp <= 2'(GRP_TOP);
            end
            if (w_pos_inc) begin
                r_pos <= r_pos + 8'd1;
            end
            if (w_ctl.advance) begin
                r_idx <= r_idx - 1'b1;
                r_grp <= (r_grp == 2'd0) ? 2'(GROUP_LEN - 1) : r_grp - 2'd1;
            end
        end
    end

    // The chain: cell 0 takes magnitude bits in from below during
    // conversion; during emission digits move one cell up per step.
    assign w_bit[0] = r_mag[VALUE_BITS-1];
    assign w_dig[0] = '0;

    for (genvar g = 0; g < DIGIT_SLOTS; g++) begin : g_cell
        sdfg_digit_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_bit      (w_bit[g]),
            .i_digit_lo (w_dig[g]),
            .o_bit      (w_bit[g+1]),
            .o_digit    (w_dig[g+1])
        );
    end

    assign o_out_valid = r_ovalid;
    assign o_out_char  = r_ochar;
    assign o_status    = r_ostat;
    assign o_last      = r_olast;

endmodule

`default_nettype wire

// ----- test/signed_decimal_format_grouped_core_tb.sv -----
// Self-checking testbench for signed_decimal_format_grouped_core: directed rows,
// then random values under four idle mixes and many register settings.
// Depends on sdfg_pkg and the block itself; needs no other file.
`timescale 1ns / 1ps

module signed_decimal_format_grouped_core_tb;
    import sdfg_pkg::*;

    // Roughly 280 values fit well below this bound, even with the result side
    // stalling often and with the sender gaps.
    localparam int unsigned CYCLE_LIMIT = 600000;

    // After the last expected beat the block should stay quiet; this many
    // cycles covers one full conversion, so a stray beat would show up.
    localparam int TAIL_CYCLES = 150;

    localparam int PHASES          = 4;
    localparam int SETTINGS_PER_PH = 4;
    localparam int VALUES_PER_SET  = 16;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [STAT_W-1:0] st;
        logic              last;
    } t_beat;

    // One row of the directed table. When typed is set, the expected text and
    // the closing status are written out in the row itself; otherwise the
    // formatter model below works out the beats.
    typedef struct {
        logic [7:0]         sep;
        logic [7:0]         size;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        string              text;
        logic [STAT_W-1:0]  tail;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [VALUE_W-1:0] i_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [CHAR_W-1:0]  o_out_char;
    logic [STAT_W-1:0]  o_status;
    logic               o_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    signed_decimal_format_grouped_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_status    (o_status),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // The model's copy of the two registers, updated on every write.
    logic [7:0]  cur_sep  = SEP_RST;
    logic [7:0]  cur_size = SIZE_RST;

    // Beats still owed by the block, oldest first.
    t_beat       expected_beats [$];
    t_row        rows [$];

    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    int          mismatches    = 0;
    int          beats_checked = 0;
    int          values_sent   = 0;
    int          settings_used = 0;
    int unsigned cycle_count   = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or stops answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still owed", cycle_count,
                     expected_beats.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endfunction

    // Formats one value the way the block should, under the current register
    // copy, and appends the resulting beats to the expected queue.
    function automatic void format_expected(input logic [VALUE_W-1:0] v);
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits [32];
        t_beat              seq [32];
        int                 nd;
        int                 pos;
        int                 n;
        int                 i;
        bit                 stop;
        n = 0;
        stop = 1'b0;
        if (cur_size == 8'd0) begin
            // A zero-length buffer gets a single error beat and nothing else.
            seq[0] = '{8'd0, ST_SIZE, 1'b1};
            n = 1;
        end else begin
            neg = v[VALUE_W-1];
            // Negating the most negative value wraps to itself, which is
            // exactly its magnitude when read as unsigned.
            mag = neg ? (~v + 1'b1) : v;
            nd = 0;
            if (mag == '0) begin
                digits[0] = 4'd0;
                nd = 1;
            end
            while (mag != '0) begin
                digits[nd] = 4'(mag % 10);
                mag = mag / 10;
                nd++;
            end
            pos = 0;
            if (neg) begin
                // The sign needs room for itself and the terminator.
                if (pos + 1 >= int'(cur_size)) begin
                    seq[n] = '{8'd0, ST_OVF, 1'b1};
                    n++;
                    stop = 1'b1;
                end else begin
                    seq[n] = '{CH_MINUS, ST_OK, 1'b0};
                    n++;
                    pos++;
                end
            end
            for (i = nd - 1; i >= 0 && !stop; i--) begin
                // Each digit reserves one more byte than the sign does; a
                // separator after it rides along without a check of its own.
                if (pos + 2 >= int'(cur_size)) begin
                    seq[n] = '{8'd0, ST_OVF, 1'b1};
                    n++;
                    stop = 1'b1;
                end else begin
                    seq[n] = '{CH_ZERO + {4'd0, digits[i]}, ST_OK, 1'b0};
                    n++;
                    pos++;
                    if (cur_sep != 8'd0 && i > 0 && (i % GROUP_LEN) == 0) begin
                        seq[n] = '{cur_sep, ST_OK, 1'b0};
                        n++;
                        pos++;
                    end
                end
            end
        end
        seq[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            expected_beats.push_back(seq[i]);
    endfunction

    // Appends beats spelled out by hand: the characters, then either last on
    // the final character or a closing error beat.
    function automatic void queue_typed(input string text, input logic [STAT_W-1:0] tail);
        t_beat b;
        int    i;
        for (i = 0; i < text.len(); i++) begin
            b.ch   = text[i];
            b.st   = ST_OK;
            b.last = (tail == ST_OK) && (i == text.len() - 1);
            expected_beats.push_back(b);
        end
        if (tail != ST_OK) begin
            b = '{8'd0, tail, 1'b1};
            expected_beats.push_back(b);
        end
    endfunction

    function automatic void add_row(input logic [7:0] sep, input logic [7:0] size,
                                    input logic [VALUE_W-1:0] value, input bit typed,
                                    input string text, input logic [STAT_W-1:0] tail);
        t_row r;
        r.sep   = sep;
        r.size  = size;
        r.value = value;
        r.typed = typed;
        r.text  = text;
        r.tail  = tail;
        rows.push_back(r);
    endfunction

    // APB write: setup cycle, access cycle, register taken at the edge after.
    task automatic reg_write(input logic [2:0] addr, input logic [7:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, data};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // APB read, compared against what the register should hold. The read data
    // is sampled mid-way through the access cycle, clear of the clock edge.
    task automatic reg_check(input logic [2:0] addr, input logic [7:0] want);
        logic [7:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata[7:0];
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            note_mismatch($sformatf("register at %0d reads %h, expected %h", addr, got, want));
    endtask

    task automatic set_registers(input logic [7:0] sep, input logic [7:0] size);
        reg_write({REG_SEP, 2'b00}, sep);
        reg_write({REG_SIZE, 2'b00}, size);
        cur_sep  = sep;
        cur_size = size;
        reg_check({REG_SEP, 2'b00}, sep);
        reg_check({REG_SIZE, 2'b00}, size);
        settings_used++;
    endtask

    // Lowers the input valid and waits until every owed beat has come back,
    // so the block is idle before the registers change.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
    endtask

    // Offers one value on the input channel, after a random gap, and holds it
    // until the block takes the beat. Valid is only ever lowered in a step
    // where it is not raised again.
    task automatic push_value(input logic [VALUE_W-1:0] v, input bit typed,
                              input string text, input logic [STAT_W-1:0] tail);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do
            @(posedge i_clk);
        while (o_in_stall);
        if (typed)
            queue_typed(text, tail);
        else
            format_expected(v);
        values_sent++;
    endtask

    // Random values lean toward the interesting corners: group boundaries at
    // powers of ten, small numbers, both extremes, and plain 64-bit noise.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        int                 k;
        case ($urandom_range(9))
            0, 1, 2: v = {$urandom, $urandom};
            3:       v = VALUE_W'($urandom_range(0, 9999));
            4: begin
                v = 1;
                k = $urandom_range(0, 18);
                repeat (k) v = v * 10;
                v = v - 1 + VALUE_W'($urandom_range(0, 2));
            end
            5:       v = {$urandom, $urandom} >> $urandom_range(1, 63);
            6: begin
                case ($urandom_range(3))
                    0:       v = {1'b1, {(VALUE_W-1){1'b0}}};
                    1:       v = {1'b0, {(VALUE_W-1){1'b1}}};
                    2:       v = '1;
                    default: v = '0;
                endcase
            end
            default: v = VALUE_W'($urandom);
        endcase
        if ($urandom_range(1) == 1 && $urandom_range(2) == 0)
            v = ~v + 1'b1;
        return v;
    endfunction

    // Result side: takes beats whenever stall is low, checks each against the
    // oldest expectation and picks the next stall at random.
    always @(posedge i_clk) begin
        t_beat want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                beats_checked++;
                if (expected_beats.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat char %h status %0d last %b",
                                            o_out_char, o_status, o_last));
                end else begin
                    want = expected_beats.pop_front();
                    if (o_out_char !== want.ch || o_status !== want.st ||
                        o_last !== want.last)
                        note_mismatch($sformatf(
                            "beat char %h status %0d last %b, expected %h %0d %b",
                            o_out_char, o_status, o_last, want.ch, want.st, want.last));
                end
            end
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    initial begin
        int in_mix  [PHASES];
        int out_mix [PHASES];
        int r;
        int p;
        int s;
        int j;
        logic [7:0] sep;
        logic [7:0] size;

        in_mix  = '{0, 54, 0, 29};
        out_mix = '{0, 0, 54, 29};

        // Directed table. The first rows run on the reset register values.
        add_row(8'd0, 8'd32, 64'd0, 1'b1, "0", ST_OK);
        add_row(8'd0, 8'd32, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, "9223372036854775807", ST_OK);
        add_row(8'd0, 8'd32, 64'h8000_0000_0000_0000, 1'b1, "-9223372036854775808", ST_OK);
        add_row(8'd0, 8'd32, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "-1", ST_OK);
        // Comma grouping on both extremes and on smaller values.
        add_row(8'h2C, 8'd32, 64'h8000_0000_0000_0000, 1'b1,
                "-9,223,372,036,854,775,808", ST_OK);
        add_row(8'h2C, 8'd32, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
                "9,223,372,036,854,775,807", ST_OK);
        add_row(8'h2C, 8'd32, 64'd999, 1'b0, "", ST_OK);
        add_row(8'h2C, 8'd32, 64'd1000, 1'b1, "1,000", ST_OK);
        add_row(8'h2C, 8'd32, -64'd123456, 1'b0, "", ST_OK);
        add_row(8'h2C, 8'd32, 64'd12345678, 1'b0, "", ST_OK);
        // Zero buffer size gives the size error and nothing else.
        add_row(8'h2C, 8'd0, 64'd5, 1'b1, "", ST_SIZE);
        add_row(8'h2C, 8'd0, -64'd5, 1'b1, "", ST_SIZE);
        // Tiny buffers: the sign check fails first, then the digit check.
        add_row(8'h2C, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "", ST_OVF);
        add_row(8'h2C, 8'd1, 64'd7, 1'b1, "", ST_OVF);
        add_row(8'h2C, 8'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "-", ST_OVF);
        add_row(8'h2C, 8'd2, 64'd7, 1'b1, "", ST_OVF);
        add_row(8'h2C, 8'd3, 64'd7, 1'b1, "7", ST_OK);
        add_row(8'h2C, 8'd3, 64'd42, 1'b1, "4", ST_OVF);
        // Overflow right after a separator, which took its byte unchecked.
        add_row(8'h2E, 8'd6, 64'd123456, 1'b0, "", ST_OK);
        // Largest buffer, with the largest separator byte and then with none.
        add_row(8'hFF, 8'd255, 64'h8000_0000_0000_0000, 1'b0, "", ST_OK);
        add_row(8'hFF, 8'd255, 64'd1234567, 1'b0, "", ST_OK);
        add_row(8'd0, 8'd255, 64'd1000000, 1'b0, "", ST_OK);
        add_row(8'd0, 8'd255, -64'd1000, 1'b0, "", ST_OK);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Both registers must come out of reset at their documented values.
        reg_check({REG_SEP, 2'b00}, SEP_RST);
        reg_check({REG_SIZE, 2'b00}, SIZE_RST);

        for (r = 0; r < rows.size(); r++) begin
            if (rows[r].sep !== cur_sep || rows[r].size !== cur_size) begin
                drain();
                set_registers(rows[r].sep, rows[r].size);
            end
            push_value(rows[r].value, rows[r].typed, rows[r].text, rows[r].tail);
        end

        // Random part: each idle mix runs through several register settings,
        // most with room for the full text and some small enough to overflow.
        for (p = 0; p < PHASES; p++) begin
            for (s = 0; s < SETTINGS_PER_PH; s++) begin
                case (s)
                    0: begin
                        sep  = 8'h2C;
                        size = 8'd255;
                    end
                    1: begin
                        sep  = 8'd0;
                        size = 8'($urandom_range(28, 254));
                    end
                    2: begin
                        sep  = 8'($urandom_range(1, 255));
                        size = 8'($urandom_range(0, 30));
                    end
                    default: begin
                        sep  = 8'($urandom_range(0, 255));
                        size = 8'd32;
                    end
                endcase
                drain();
                set_registers(sep, size);
                in_idle_pct   = in_mix[p];
                out_stall_pct = out_mix[p];
                for (j = 0; j < VALUES_PER_SET; j++)
                    push_value(pick_value(), 1'b0, "", ST_OK);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_beats.size() != 0)
            note_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));

        $display("Formatted %0d values over %0d register settings and four idle mixes.",
                 values_sent, settings_used);
        $display("Checked %0d result beats; %0d mismatches counted.", beats_checked,
                 mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
